// ----- src/svt_pkg.sv -----
// Shared types, constants and helpers for the voice stream tracker.
`timescale 1ns / 1ps

package svt_pkg;

  // Message and queue sizing, and the watchdog limit loaded at reset
  localparam int unsigned TEXT_LEN      = 20;
  localparam int unsigned JOB_DEPTH     = 2;
  localparam logic [7:0]  WD_LIMIT_RST  = 8'd100;

  // Slow-data sync pattern, scrambler bytes, header base, last stage and end bit
  localparam logic [7:0] SYNC_B0     = 8'h55;
  localparam logic [7:0] SYNC_B1     = 8'h2d;
  localparam logic [7:0] SYNC_B2     = 8'h16;
  localparam logic [7:0] SCRAMBLE_B0 = 8'h70;
  localparam logic [7:0] SCRAMBLE_B1 = 8'h4f;
  localparam logic [7:0] SCRAMBLE_B2 = 8'h93;
  localparam logic [7:0] HDR_BASE    = 8'h30;
  localparam logic [3:0] LAST_STAGE  = 4'd8;
  localparam int unsigned END_BIT    = 6;

  typedef enum logic [1:0] {
    ReqVoice = 2'd0,
    ReqPing  = 2'd1,
    ReqTick  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    StIdle      = 3'd0,
    StNew       = 3'd1,
    StStreaming = 3'd2,
    StEnded     = 3'd3,
    StLost      = 3'd4
  } stream_e;

  typedef enum logic {
    KindStatus = 1'b0,
    KindText   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        transmitting;
    logic [15:0] frame_stream_id;
    logic [7:0]  frame_byte;
    logic [7:0]  slow_byte0;
    logic [7:0]  slow_byte1;
    logic [7:0]  slow_byte2;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [2:0]  stream_status;
    logic [15:0] current_stream_id;
    logic [7:0]  text_char;
    logic [4:0]  text_index;
    logic        last;
  } out_item_t;

  // One job per accepted item, handed from front to back
  typedef struct packed {
    stream_e     status;
    logic [15:0] stream_id;
    logic        done;
  } job_t;

  // Text store write from the front
  typedef struct packed {
    logic       en;
    logic       odd;
    logic [4:0] first;
    logic [7:0] d0;
    logic [7:0] d1;
    logic [7:0] d2;
  } store_wr_t;

  // Store index of the first text byte carried by a stage
  function automatic logic [4:0] text_pos(input logic [3:0] stage);
    logic [4:0] pos;
    case (stage)
      4'd1:    pos = 5'd0;
      4'd2:    pos = 5'd2;
      4'd3:    pos = 5'd5;
      4'd4:    pos = 5'd7;
      4'd5:    pos = 5'd10;
      4'd6:    pos = 5'd12;
      4'd7:    pos = 5'd15;
      4'd8:    pos = 5'd17;
      default: pos = 5'd0;
    endcase
    return pos;
  endfunction

endpackage

// ----- src/svt_text_store.sv -----
// Twenty-byte text register file: one frame write, one read port.
`timescale 1ns / 1ps

module svt_text_store (
  input  logic                 clk_i,
  input  svt_pkg::store_wr_t   wr_i,
  input  logic [4:0]           rd_addr_i,
  output logic [7:0]           rd_data_o
);

  logic [7:0] mem_q [svt_pkg::TEXT_LEN];

  // Each lane picks its byte by its offset from the frame's first position
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < svt_pkg::TEXT_LEN; i++) begin
      if (wr_i.en) begin
        if (5'(i) == wr_i.first) begin
          mem_q[i] <= wr_i.odd ? wr_i.d1 : wr_i.d0;
        end else if (5'(i) == wr_i.first + 5'd1) begin
          mem_q[i] <= wr_i.odd ? wr_i.d2 : wr_i.d1;
        end else if (!wr_i.odd && (5'(i) == wr_i.first + 5'd2)) begin
          mem_q[i] <= wr_i.d2;
        end
      end
    end
  end

  assign rd_data_o = mem_q[rd_addr_i];

endmodule

// ----- src/svt_front.sv -----
// Front end: accepts events, tracks stream state, decodes slow data.
`timescale 1ns / 1ps

module svt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  svt_pkg::in_item_t   in_i,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                job_full_i,
  output logic                job_push_o,
  output svt_pkg::job_t       job_o,
  output svt_pkg::store_wr_t  store_wr_o,
  input  logic                msg_done_i
);

  svt_pkg::stream_e state_q, state_d;
  logic [15:0] held_id_q, held_id_d;
  logic [7:0]  wd_cnt_q, wd_cnt_d;
  logic        sync_q, sync_d;
  logic [3:0]  stage_q, stage_d;
  logic [7:0]  wd_limit_q;
  logic        busy_q;
  logic        accept;
  logic        done;
  logic        is_sync;
  logic        in_seq;
  logic [7:0]  hdr;
  logic [1:0]  pair;

  // Hold off while the queue is full or the store is still being read out
  assign full_o     = job_full_i | busy_q;
  assign accept     = push_i & ~full_o;
  assign job_push_o = accept;

  assign pair    = 2'((stage_q - 4'd1) >> 1);
  assign hdr     = svt_pkg::HDR_BASE + {6'd0, pair};
  assign is_sync = (in_i.frame_byte == 8'd0) && (in_i.slow_byte0 == svt_pkg::SYNC_B0) &&
                   (in_i.slow_byte1 == svt_pkg::SYNC_B1) &&
                   (in_i.slow_byte2 == svt_pkg::SYNC_B2);
  assign in_seq  = sync_q && (stage_q >= 4'd1) && (stage_q <= svt_pkg::LAST_STAGE) &&
                   (in_i.frame_byte == {4'd0, stage_q});

  // Event decode and next state
  always_comb begin
    state_d    = state_q;
    held_id_d  = held_id_q;
    wd_cnt_d   = wd_cnt_q;
    sync_d     = sync_q;
    stage_d    = stage_q;
    done       = 1'b0;
    store_wr_o.en    = 1'b0;
    store_wr_o.odd   = stage_q[0];
    store_wr_o.first = svt_pkg::text_pos(stage_q);
    store_wr_o.d0    = in_i.slow_byte0 ^ svt_pkg::SCRAMBLE_B0;
    store_wr_o.d1    = in_i.slow_byte1 ^ svt_pkg::SCRAMBLE_B1;
    store_wr_o.d2    = in_i.slow_byte2 ^ svt_pkg::SCRAMBLE_B2;

    case (svt_pkg::req_e'(in_i.req_type))
      svt_pkg::ReqVoice: begin
        wd_cnt_d = 8'd0;
        if (!in_i.transmitting && (held_id_q == 16'd0)) begin
          held_id_d = in_i.frame_stream_id;
          state_d   = svt_pkg::StNew;
        end else begin
          state_d = svt_pkg::StStreaming;
        end
        // slow-data sequence
        if (is_sync) begin
          sync_d  = 1'b1;
          stage_d = 4'd1;
        end else if (in_seq) begin
          if (stage_q[0]) begin
            if (in_i.slow_byte0 == hdr) begin
              store_wr_o.en = accept;
              stage_d       = stage_q + 4'd1;
            end
          end else begin
            store_wr_o.en = accept;
            if (stage_q == svt_pkg::LAST_STAGE) begin
              sync_d  = 1'b0;
              stage_d = 4'd0;
              done    = 1'b1;
            end else begin
              stage_d = stage_q + 4'd1;
            end
          end
        end
        // end of stream overrides
        if (in_i.frame_byte[svt_pkg::END_BIT]) begin
          wd_cnt_d  = 8'd0;
          state_d   = svt_pkg::StEnded;
          held_id_d = 16'd0;
        end
      end
      svt_pkg::ReqPing: begin
        if ((state_q == svt_pkg::StLost) || (state_q == svt_pkg::StEnded)) begin
          state_d = svt_pkg::StIdle;
        end
      end
      svt_pkg::ReqTick: begin
        if (wd_cnt_q > wd_limit_q) begin
          wd_cnt_d  = 8'd0;
          state_d   = svt_pkg::StLost;
          held_id_d = 16'd0;
        end else begin
          wd_cnt_d = wd_cnt_q + 8'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign job_o.status    = state_d;
  assign job_o.stream_id = held_id_d;
  assign job_o.done      = done;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= svt_pkg::StIdle;
      held_id_q  <= 16'd0;
      wd_cnt_q   <= 8'd0;
      sync_q     <= 1'b0;
      stage_q    <= 4'd0;
      wd_limit_q <= svt_pkg::WD_LIMIT_RST;
      busy_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wd_limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        state_q   <= state_d;
        held_id_q <= held_id_d;
        wd_cnt_q  <= wd_cnt_d;
        sync_q    <= sync_d;
        stage_q   <= stage_d;
      end
      if (accept && done) begin
        busy_q <= 1'b1;
      end else if (msg_done_i) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

// ----- src/svt_job_fifo.sv -----
// Short job queue between front and back.
`timescale 1ns / 1ps

module svt_job_fifo #(
  parameter int unsigned Depth = svt_pkg::JOB_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  svt_pkg::job_t  data_i,
  output logic           full_o,
  input  logic           pop_i,
  output svt_pkg::job_t  data_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  svt_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- src/svt_back.sv -----
// Back end: turns jobs into text and status items through an output register.
`timescale 1ns / 1ps

module svt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  svt_pkg::job_t       job_i,
  input  logic                job_empty_i,
  output logic                job_pop_o,
  output logic [4:0]          rd_addr_o,
  input  logic [7:0]          rd_data_i,
  output logic                msg_done_o,
  output logic                empty_o,
  input  logic                pop_i,
  output svt_pkg::out_item_t  out_o
);

  typedef enum logic [1:0] {
    BkIdle,
    BkText,
    BkStatus
  } back_e;

  back_e              state_q;
  svt_pkg::job_t      job_q;
  logic [4:0]         idx_q;
  logic               valid_q;
  svt_pkg::out_item_t out_q;
  logic               load;

  // Output register may load when empty or being taken this cycle
  assign load       = ~valid_q | pop_i;
  assign job_pop_o  = load & (state_q == BkIdle) & ~job_empty_i;
  assign rd_addr_o  = idx_q;
  assign msg_done_o = load & (state_q == BkText) &
                      (idx_q == 5'(svt_pkg::TEXT_LEN - 1));
  assign empty_o    = ~valid_q;
  assign out_o      = out_q;

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      idx_q   <= 5'd0;
      valid_q <= 1'b0;
      job_q   <= '0;
      out_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b0;
      case (state_q)
        BkIdle: begin
          if (!job_empty_i) begin
            job_q   <= job_i;
            valid_q <= 1'b1;
            out_q.stream_status     <= job_i.status;
            out_q.current_stream_id <= job_i.stream_id;
            if (job_i.done) begin
              out_q.out_kind   <= svt_pkg::KindText;
              out_q.text_char  <= rd_data_i;
              out_q.text_index <= 5'd0;
              out_q.last       <= 1'b0;
              idx_q            <= 5'd1;
              state_q          <= BkText;
            end else begin
              out_q.out_kind   <= svt_pkg::KindStatus;
              out_q.text_char  <= 8'd0;
              out_q.text_index <= 5'd0;
              out_q.last       <= 1'b1;
            end
          end
        end
        BkText: begin
          valid_q <= 1'b1;
          out_q.out_kind          <= svt_pkg::KindText;
          out_q.stream_status     <= job_q.status;
          out_q.current_stream_id <= job_q.stream_id;
          out_q.text_char         <= rd_data_i;
          out_q.text_index        <= idx_q;
          out_q.last              <= 1'b0;
          if (idx_q == 5'(svt_pkg::TEXT_LEN - 1)) begin
            idx_q   <= 5'd0;
            state_q <= BkStatus;
          end else begin
            idx_q <= idx_q + 5'd1;
          end
        end
        BkStatus: begin
          valid_q <= 1'b1;
          out_q.out_kind          <= svt_pkg::KindStatus;
          out_q.stream_status     <= job_q.status;
          out_q.current_stream_id <= job_q.stream_id;
          out_q.text_char         <= 8'd0;
          out_q.text_index        <= 5'd0;
          out_q.last              <= 1'b1;
          state_q                 <= BkIdle;
        end
        default: begin
          state_q <= BkIdle;
        end
      endcase
    end
  end

endmodule

// ----- src/voice_stream_tracker_slow_data_rx.sv -----
// Top level of the voice stream tracker and slow-data text receiver.
//
// Usage: events (voice frame, keep-alive, timer tick) enter as in_i when push
// is high and full is low. Results leave as out_o while empty is low and are
// taken with pop. Every event gives one status item with last set; a voice
// frame that completes the 20-byte slow-data message first gives the 20
// descrambled text characters, index 0 to 19, then its status item.
// The watchdog limit is written with cfg_we_i / cfg_wdata_i while idle.
//
// Flow: an accepted event is written into the job queue, and its first result
// is then loaded from there into the output register. Status-only events
// stream at one per cycle while the receiver keeps taking them; a completing
// frame gives 21 items as the back end reads the text store one byte a cycle,
// again while the receiver keeps taking them. Further events are held off
// (full) until the last character has been read from the store. Reset clears
// the stream state, watchdog, sync tracking, queue and output register and
// loads the watchdog limit of 100. When the receiver stalls, the output
// register holds its item and the job queue fills, then full rises.
`timescale 1ns / 1ps

module voice_stream_tracker_slow_data_rx #(
  parameter int unsigned JobDepth = svt_pkg::JOB_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  svt_pkg::in_item_t   in_i,
  output logic                empty,
  input  logic                pop,
  output svt_pkg::out_item_t  out_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);

  logic               job_full, job_push, job_empty, job_pop, msg_done;
  svt_pkg::job_t      job_in, job_out;
  svt_pkg::store_wr_t store_wr;
  logic [4:0]         rd_addr;
  logic [7:0]         rd_data;

  svt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_full_i  (job_full),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .store_wr_o  (store_wr),
    .msg_done_i  (msg_done)
  );

  svt_text_store u_store (
    .clk_i     (clk_i),
    .wr_i      (store_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  svt_job_fifo #(
    .Depth (JobDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  svt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .msg_done_o  (msg_done),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_o       (out_o)
  );

endmodule

// ----- tb/sv/voice_stream_tracker_slow_data_rx_tb.sv -----
// Self-checking testbench for the voice stream tracker and slow-data text receiver.
`timescale 1ns / 1ps

module voice_stream_tracker_slow_data_rx_tb;
  import svt_pkg::*;

  // Request code the block must treat as a no-op
  localparam logic [1:0] ReqUndef = 2'd3;

  localparam int unsigned WATCHDOG_CYCLES = 5000;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned TAIL_CYCLES     = 30;
  localparam int unsigned MAX_REPORTS     = 10;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  in_item_t   in_i;
  logic       empty;
  logic       pop;
  out_item_t  out_o;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  voice_stream_tracker_slow_data_rx dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Tracker copy kept by the testbench
  stream_e     trk_state = StIdle;
  logic [15:0] trk_id    = '0;
  logic [7:0]  trk_wd    = '0;
  logic [7:0]  trk_limit = WD_LIMIT_RST;
  logic        trk_sync  = 1'b0;
  logic [3:0]  trk_stage = '0;
  logic [7:0]  trk_text [TEXT_LEN];

  // Results still to come out of the block, oldest first
  out_item_t due_results [$];

  int items_sent    = 0;
  int results_seen  = 0;
  int text_seen     = 0;
  int messages_done = 0;
  int lost_events   = 0;
  int limit_writes  = 0;
  int failures      = 0;
  int idle_cycles   = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Long receiver hold-off, requested by toggling hold_kick
  logic hold_kick = 1'b0;
  logic hold_ack  = 1'b0;
  int   hold_left = 0;

  // Slow-data sequencer: returns 1 when frame 8 completes the message
  function automatic logic decode_slow_data(input in_item_t it);
    int pair;
    int pos;
    if (it.frame_byte == 8'd0 && it.slow_byte0 == SYNC_B0 &&
        it.slow_byte1 == SYNC_B1 && it.slow_byte2 == SYNC_B2) begin
      trk_sync  = 1'b1;
      trk_stage = 4'd1;
      return 1'b0;
    end
    if (!trk_sync || trk_stage < 4'd1 || trk_stage > LAST_STAGE ||
        it.frame_byte != {4'd0, trk_stage}) begin
      return 1'b0;
    end
    pair = (int'(trk_stage) - 1) / 2;
    pos  = pair * 5;
    if (trk_stage[0]) begin
      // odd stage: header byte then two text bytes
      if (it.slow_byte0 != HDR_BASE + pair[7:0]) begin
        return 1'b0;
      end
      trk_text[pos]     = it.slow_byte1 ^ SCRAMBLE_B1;
      trk_text[pos + 1] = it.slow_byte2 ^ SCRAMBLE_B2;
      trk_stage = trk_stage + 4'd1;
      return 1'b0;
    end
    pos = pos + 2;
    trk_text[pos]     = it.slow_byte0 ^ SCRAMBLE_B0;
    trk_text[pos + 1] = it.slow_byte1 ^ SCRAMBLE_B1;
    trk_text[pos + 2] = it.slow_byte2 ^ SCRAMBLE_B2;
    if (trk_stage == LAST_STAGE) begin
      trk_sync  = 1'b0;
      trk_stage = 4'd0;
      return 1'b1;
    end
    trk_stage = trk_stage + 4'd1;
    return 1'b0;
  endfunction

  // Apply one accepted event and queue the results it must produce
  function automatic void track_event(input in_item_t it);
    logic      done;
    out_item_t r;
    int        i;
    done = 1'b0;
    case (it.req_type)
      ReqVoice: begin
        trk_wd = '0;
        if (!it.transmitting && trk_id == 16'd0) begin
          trk_id    = it.frame_stream_id;
          trk_state = StNew;
        end else begin
          trk_state = StStreaming;
        end
        done = decode_slow_data(it);
        // end of stream is applied after the text handling
        if (it.frame_byte[END_BIT]) begin
          trk_wd    = '0;
          trk_state = StEnded;
          trk_id    = '0;
        end
      end
      ReqPing: begin
        if (trk_state == StLost || trk_state == StEnded) trk_state = StIdle;
      end
      ReqTick: begin
        if (trk_wd > trk_limit) begin
          trk_wd    = '0;
          trk_state = StLost;
          trk_id    = '0;
        end else begin
          trk_wd = trk_wd + 8'd1;
        end
      end
      default: ;
    endcase

    r.stream_status     = trk_state;
    r.current_stream_id = trk_id;
    if (done) begin
      messages_done++;
      for (i = 0; i < TEXT_LEN; i++) begin
        r.out_kind   = KindText;
        r.text_char  = trk_text[i];
        r.text_index = i[4:0];
        r.last       = 1'b0;
        due_results.push_back(r);
      end
    end
    if (trk_state == StLost) lost_events++;
    r.out_kind   = KindStatus;
    r.text_char  = '0;
    r.text_index = '0;
    r.last       = 1'b1;
    due_results.push_back(r);
  endfunction

  function automatic in_item_t voice_frame(input logic tx, input logic [15:0] id,
                                           input logic [7:0] fb, input logic [7:0] b0,
                                           input logic [7:0] b1, input logic [7:0] b2);
    in_item_t it;
    it.req_type        = ReqVoice;
    it.transmitting    = tx;
    it.frame_stream_id = id;
    it.frame_byte      = fb;
    it.slow_byte0      = b0;
    it.slow_byte1      = b1;
    it.slow_byte2      = b2;
    return it;
  endfunction

  // Any request type, every other field random
  function automatic in_item_t random_event(input logic [1:0] req);
    in_item_t it;
    it = voice_frame(1'($urandom_range(1)), 16'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
    it.req_type = req;
    return it;
  endfunction

  function automatic logic [15:0] pick_id();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one item and wait until the block takes it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    track_event(it);
    items_sent++;
  endtask

  // Configuration is only written once the block has drained
  task automatic write_limit(input logic [7:0] value);
    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    trk_limit = value;
    limit_writes++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic in_item_t sync_frame(input logic tx, input logic [15:0] id);
    return voice_frame(tx, id, 8'd0, SYNC_B0, SYNC_B1, SYNC_B2);
  endfunction

  // Well-formed frame for one stage, random text
  task automatic send_stage(input logic tx, input logic [15:0] id, input int stage);
    logic [7:0] b0;
    b0 = (stage % 2 == 1) ? HDR_BASE + 8'((stage - 1) / 2) : 8'($urandom);
    send_item(voice_frame(tx, id, 8'(stage), b0, 8'($urandom), 8'($urandom)));
  endtask

  // Disturbance inside a message
  task automatic send_noise(input logic tx, input logic [15:0] id, input int stage);
    logic [7:0] hdr;
    hdr = HDR_BASE + 8'((stage - 1) / 2);
    case ($urandom_range(5))
      0: send_item(random_event(ReqTick));
      1: send_item(random_event(ReqPing));
      2: send_item(random_event(2'($urandom_range(3))));
      3: send_item(voice_frame(tx, id, 8'(stage + 1), hdr, 8'($urandom), 8'($urandom)));
      4: send_item(voice_frame(tx, id, 8'(stage) | 8'h40, hdr, 8'($urandom), 8'($urandom)));
      default: begin
        if (stage % 2 == 1) begin
          send_item(voice_frame(tx, id, 8'(stage), hdr ^ 8'($urandom_range(1, 255)),
                                8'($urandom), 8'($urandom)));
        end else begin
          send_item(voice_frame(tx, id, 8'(stage) | 8'h80, 8'($urandom), 8'($urandom),
                                8'($urandom)));
        end
      end
    endcase
  endtask

  // Sync plus frames 1..8, with occasional noise, resync or abandon
  task automatic send_message();
    int          stage;
    logic [15:0] id;
    logic        tx;
    id = pick_id();
    tx = ($urandom_range(9) == 0);
    send_item(sync_frame(tx, id));
    stage = 1;
    while (stage <= 8) begin
      if ($urandom_range(99) < 12) begin
        send_noise(tx, id, stage);
      end else if ($urandom_range(99) < 2) begin
        stage = 99;
      end else if ($urandom_range(99) < 3) begin
        send_item(sync_frame(tx, id));
        stage = 1;
      end else begin
        send_stage(tx, id, stage);
        stage++;
      end
    end
    if ($urandom_range(3) == 0) begin
      send_item(voice_frame(tx, id, 8'h40 | 8'($urandom_range(63)), 8'($urandom),
                            8'($urandom), 8'($urandom)));
    end
  endtask

  // Idle, capture, id zero, transmit block, end of stream, keep-alive
  task automatic test_stream_states();
    send_item(random_event(ReqPing));
    send_item(random_event(ReqUndef));
    send_item(random_event(ReqTick));
    send_item(voice_frame(1'b1, 16'h8001, 8'h01, 8'h00, 8'h00, 8'h00));
    send_item(voice_frame(1'b0, 16'h0000, 8'h20, 8'hff, 8'hff, 8'hff));
    send_item(voice_frame(1'b0, 16'hffff, 8'h10, 8'h00, 8'h00, 8'h00));
    send_item(voice_frame(1'b0, 16'h1111, 8'h02, 8'h00, 8'h00, 8'h00));
    send_item(voice_frame(1'b0, 16'h2222, 8'hff, 8'hff, 8'hff, 8'hff));
    send_item(random_event(ReqPing));
  endtask

  // Message decode with bad header, out-of-order frame, end bit and resync
  task automatic test_text_message();
    int s;
    send_item(sync_frame(1'b0, 16'h0001));
    send_item(voice_frame(1'b0, 16'h0001, 8'd1, HDR_BASE, 8'h00, 8'hff));
    send_item(voice_frame(1'b0, 16'h0001, 8'd2, 8'h00, 8'hff, 8'h80));
    send_item(voice_frame(1'b0, 16'h0001, 8'd3, HDR_BASE + 8'd5, 8'h00, 8'hff));
    send_item(voice_frame(1'b0, 16'h0001, 8'd4, 8'h00, 8'hff, 8'h80));
    send_item(voice_frame(1'b0, 16'h0001, 8'd3, HDR_BASE + 8'd1, 8'h00, 8'hff));
    // resync in mid-message, then a frame 1 that carries the end bit
    send_item(sync_frame(1'b0, 16'h0001));
    send_item(voice_frame(1'b0, 16'h0001, 8'h41, HDR_BASE, 8'h12, 8'h34));
    for (s = 1; s <= 8; s++) begin
      if (s % 2 == 1) begin
        send_item(voice_frame(1'b0, 16'hfffe, 8'(s), HDR_BASE + 8'((s - 1) / 2),
                              8'h00, 8'hff));
      end else begin
        send_item(voice_frame(1'b0, 16'hfffe, 8'(s), 8'h00, 8'hff, 8'h80));
      end
    end
  endtask

  // Zero limit: second tick without a frame loses the stream
  task automatic test_watchdog_lost();
    write_limit(8'd0);
    send_item(voice_frame(1'b0, 16'h4321, 8'h05, 8'h00, 8'h00, 8'h00));
    send_item(random_event(ReqTick));
    send_item(random_event(ReqTick));
    send_item(random_event(ReqPing));
  endtask

  // Full limit: the count wraps instead of declaring loss
  task automatic test_watchdog_wrap();
    write_limit(8'd255);
    repeat (258) send_item(random_event(ReqTick));
    send_item(random_event(ReqPing));
  endtask

  task automatic test_random_traffic(input int count, input logic [7:0] limit);
    int target;
    write_limit(limit);
    target = items_sent + count;
    while (items_sent < target) begin
      case ($urandom_range(7))
        0:       send_item(random_event(2'($urandom_range(3))));
        1:       repeat ($urandom_range(1, 8)) send_item(random_event(ReqTick));
        default: send_message();
      endcase
    end
  endtask

  // Receiver holds off while messages keep coming, so the input stalls
  task automatic test_backpressure();
    write_limit(8'd200);
    set_idling(0, 0);
    hold_kick <= ~hold_kick;
    repeat (3) send_message();
  endtask

  // Receiver: check every accepted result, then choose pop for the next edge
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (out_o.out_kind == KindText) text_seen++;
        if (due_results.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS) $display("unexpected result item: %p", out_o);
        end else begin
          want = due_results.pop_front();
          if (out_o.out_kind !== want.out_kind ||
              out_o.stream_status !== want.stream_status ||
              out_o.current_stream_id !== want.current_stream_id ||
              out_o.text_char !== want.text_char ||
              out_o.text_index !== want.text_index ||
              out_o.last !== want.last) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
              $display("result %0d wrong: kind %0d/%0d status %0d/%0d id %h/%h",
                       results_seen, out_o.out_kind, want.out_kind, out_o.stream_status,
                       want.stream_status, out_o.current_stream_id,
                       want.current_stream_id);
              $display("  char %h/%h index %0d/%0d last %0d/%0d (got/expected)",
                       out_o.text_char, want.text_char, out_o.text_index,
                       want.text_index, out_o.last, want.last);
            end
          end
        end
      end
      if (hold_kick != hold_ack) begin
        hold_ack  <= hold_kick;
        hold_left <= HOLD_CYCLES;
        pop       <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                  idle_cycles, due_results.size());
        $display("voice_stream_tracker_slow_data_rx: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    foreach (trk_text[i]) trk_text[i] = '0;
    rst_ni      = 1'b0;
    push        = 1'b0;
    in_i        = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0, 0);
    test_stream_states();
    test_text_message();
    test_watchdog_lost();
    test_watchdog_wrap();

    set_idling(0, 0);
    test_random_traffic(40, 8'd3);
    set_idling(86, 0);
    test_random_traffic(40, 8'($urandom_range(1, 254)));
    set_idling(0, 86);
    test_random_traffic(40, 8'd1);
    set_idling(28, 28);
    test_random_traffic(40, WD_LIMIT_RST);
    test_backpressure();

    // drain and let the block settle
    push <= 1'b0;
    set_idling(0, 28);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0) begin
      failures++;
      $display("%0d expected results never arrived", due_results.size());
    end

    $display("run: %0d events, %0d results checked (%0d text chars, %0d messages)",
             items_sent, results_seen, text_seen, messages_done);
    $display("run: %0d lost-stream statuses, %0d limit writes, %0d failures",
             lost_events, limit_writes, failures);
    if (failures == 0) begin
      $display("voice_stream_tracker_slow_data_rx: match");
    end else begin
      $display("voice_stream_tracker_slow_data_rx: mismatch");
    end
    $finish;
  end

endmodule
